// ===== hw/rtl/stu_pkg.sv =====
// Shared types and constants for the string-to-unsigned parser.
// Used by the controller, the datapath and the top level; no dependencies.

package stu_pkg;

	localparam int CHAR_W   = 8;
	localparam int RADIX_W  = 6;
	localparam int VALUE_W  = 64;
	localparam int OFFSET_W = 13;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
	localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

	localparam logic [RADIX_W-1:0] BASE_OCT = 6'd8;
	localparam logic [RADIX_W-1:0] BASE_DEC = 6'd10;
	localparam logic [RADIX_W-1:0] BASE_HEX = 6'd16;

	typedef enum logic [2:0] {
		PH_WS,
		PH_SIGNED,
		PH_ZERO,
		PH_DIGITS,
		PH_STOPPED
	} phase_t;

	// Where a newly loaded active base comes from.
	typedef enum logic [1:0] {
		BS_RADIX,
		BS_TEN,
		BS_OCT_DEFAULT,
		BS_SIXTEEN
	} base_src_t;

	typedef struct packed {
		logic      emit;
		logic      neg_load;
		logic      base_load;
		base_src_t base_src;
		logic      digit;
		logic [1:0] pos_inc;
	} dp_cmd_t;

	typedef struct packed {
		logic is_term;
		logic is_space;
		logic is_sign;
		logic is_zero;
		logic is_x;
		logic radix_zero;
		logic radix_eight;
		logic radix_sixteen;
		logic step_stop;
	} dp_status_t;

endpackage

// ===== hw/rtl/stu_ctrl.sv =====
// Controller for the string-to-unsigned parser: scan phase state machine,
// input and output handshakes, and commands to the datapath.
// Depends on stu_pkg.

module stu_ctrl
	import stu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	phase_t phase_q;
	phase_t phase_d;
	logic   out_valid_q;
	logic   accept;

	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WS;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.base_src = BS_RADIX;
		phase_d  = phase_q;
		if (accept) begin
			if (status.is_term) begin
				cmd.emit = 1'b1;
				// A lone pending zero still counts as consumed.
				cmd.pos_inc = (phase_q == PH_ZERO) ? 2'd1 : 2'd0;
				phase_d = PH_WS;
			end else begin
				case (phase_q)
					PH_WS, PH_SIGNED: begin
						if (phase_q == PH_WS && status.is_space) begin
							cmd.pos_inc = 2'd1;
						end else if (phase_q == PH_WS && status.is_sign) begin
							cmd.neg_load = 1'b1;
							cmd.pos_inc  = 2'd1;
							phase_d      = PH_SIGNED;
						end else begin
							cmd.base_load = 1'b1;
							if (status.is_zero && (status.radix_zero || status.radix_sixteen)) begin
								cmd.base_src = BS_RADIX;
								phase_d      = PH_ZERO;
							end else begin
								cmd.base_src = status.radix_zero ? BS_TEN : BS_RADIX;
								if (status.radix_eight && status.is_zero) begin
									cmd.pos_inc = 2'd1;
									phase_d     = PH_DIGITS;
								end else begin
									cmd.digit = 1'b1;
									phase_d   = status.step_stop ? PH_STOPPED : PH_DIGITS;
								end
							end
						end
					end
					PH_ZERO: begin
						cmd.base_load = 1'b1;
						if (status.is_x) begin
							cmd.base_src = BS_SIXTEEN;
							cmd.pos_inc  = 2'd2;
							phase_d      = PH_DIGITS;
						end else begin
							cmd.base_src = BS_OCT_DEFAULT;
							cmd.pos_inc  = 2'd1;
							cmd.digit    = 1'b1;
							phase_d      = status.step_stop ? PH_STOPPED : PH_DIGITS;
						end
					end
					PH_DIGITS: begin
						cmd.digit = 1'b1;
						phase_d   = status.step_stop ? PH_STOPPED : PH_DIGITS;
					end
					PH_STOPPED: begin
						phase_d = PH_STOPPED;
					end
					default: begin
						phase_d = PH_WS;
					end
				endcase
			end
		end
	end

endmodule

// ===== hw/rtl/stu_datapath.sv =====
// Datapath for the string-to-unsigned parser: character decode, radix
// register, multiply-accumulate, position counter and result register.
// Depends on stu_pkg.

module stu_datapath
	import stu_pkg::*;
#(
	parameter int MAX_LEN = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [RADIX_W-1:0]  cfg_wr_data,
	input  logic [CHAR_W-1:0]   char_code,
	input  dp_cmd_t             cmd,
	output dp_status_t          status,
	output logic [VALUE_W-1:0]  value,
	output logic [OFFSET_W-1:0] stop_offset,
	output logic                overflowed
);

	localparam int POS_W = $clog2(MAX_LEN + 1);
	localparam int EXT_W = (POS_W > OFFSET_W) ? POS_W : OFFSET_W;
	localparam logic [POS_W:0] LEN_LIM = (POS_W + 1)'(MAX_LEN);

	logic [RADIX_W-1:0] radix_q;
	logic [RADIX_W-1:0] base_q;
	logic [VALUE_W-1:0] acc_q;
	logic               neg_q;
	logic               ovf_q;
	logic [POS_W-1:0]   pos_q;

	logic [VALUE_W-1:0]  value_q;
	logic [OFFSET_W-1:0] offset_q;
	logic                ovf_out_q;

	logic [RADIX_W-1:0] base_src_val;
	logic [RADIX_W-1:0] base_next;
	logic [RADIX_W-1:0] dig;
	logic               dig_valid;
	logic               digit_bad;
	logic [69:0]        prod;
	logic [70:0]        mac;
	logic               mac_ovf;
	logic               digit_ok;
	logic [1:0]         pos_add;
	logic [POS_W:0]     pos_sum;
	logic [POS_W-1:0]   pos_sat;
	logic [EXT_W-1:0]   end_ext;
	logic [VALUE_W-1:0] result;

	// Character decode.
	always_comb begin
		dig_valid = 1'b1;
		dig       = '0;
		if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
			dig = RADIX_W'(char_code - CH_ZERO);
		end else if (char_code >= CH_UA && char_code <= CH_UZ) begin
			dig = RADIX_W'(char_code - CH_UA) + BASE_DEC;
		end else if (char_code >= CH_LA && char_code <= CH_LZ) begin
			dig = RADIX_W'(char_code - CH_LA) + BASE_DEC;
		end else begin
			dig_valid = 1'b0;
		end
	end

	assign status.is_term       = (char_code == CH_NUL);
	assign status.is_space      = char_code inside {[CH_TAB:CH_CR], CH_SPACE};
	assign status.is_sign       = (char_code == CH_PLUS) || (char_code == CH_MINUS);
	assign status.is_zero       = (char_code == CH_ZERO);
	assign status.is_x          = (char_code == CH_LX) || (char_code == CH_UX);
	assign status.radix_zero    = (radix_q == '0);
	assign status.radix_eight   = (radix_q == BASE_OCT);
	assign status.radix_sixteen = (radix_q == BASE_HEX);

	always_comb begin
		case (cmd.base_src)
			BS_RADIX:       base_src_val = radix_q;
			BS_TEN:         base_src_val = BASE_DEC;
			BS_OCT_DEFAULT: base_src_val = (base_q == '0) ? BASE_OCT : base_q;
			BS_SIXTEEN:     base_src_val = BASE_HEX;
			default:        base_src_val = radix_q;
		endcase
	end

	assign base_next = cmd.base_load ? base_src_val : base_q;

	// One digit step: acc * base + digit, overflow when anything lands above bit 63.
	assign digit_bad = (base_next == '0) || !dig_valid || (dig >= base_next);
	assign prod      = 70'(acc_q) * 70'(base_next);
	assign mac       = {1'b0, prod} + 71'(dig);
	assign mac_ovf   = |mac[70:VALUE_W];
	assign status.step_stop = digit_bad || mac_ovf;
	assign digit_ok  = cmd.digit && !digit_bad && !mac_ovf;

	assign pos_add = cmd.pos_inc + {1'b0, digit_ok};
	assign pos_sum = {1'b0, pos_q} + (POS_W + 1)'(pos_add);
	assign pos_sat = (pos_sum > LEN_LIM) ? LEN_LIM[POS_W-1:0] : pos_sum[POS_W-1:0];
	assign end_ext = EXT_W'(pos_sat);

	// A magnitude above 2^63 cannot be negated; exactly 2^63 negates to itself.
	always_comb begin
		if (ovf_q) begin
			result = '1;
		end else if (pos_sat == '0) begin
			result = '0;
		end else if (neg_q) begin
			result = (acc_q[VALUE_W-1] && |acc_q[VALUE_W-2:0]) ? '0 :
				(~acc_q + VALUE_W'(1'b1));
		end else begin
			result = acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= '0;
			base_q  <= '0;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
			pos_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				radix_q <= cfg_wr_data;
			end
			if (cmd.emit) begin
				base_q <= '0;
				acc_q  <= '0;
				neg_q  <= 1'b0;
				ovf_q  <= 1'b0;
				pos_q  <= '0;
			end else begin
				base_q <= base_next;
				pos_q  <= pos_sat;
				if (cmd.neg_load) begin
					neg_q <= (char_code == CH_MINUS);
				end
				if (digit_ok) begin
					acc_q <= mac[VALUE_W-1:0];
				end
				if (cmd.digit && !digit_bad && mac_ovf) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			value_q   <= result;
			offset_q  <= end_ext[OFFSET_W-1:0];
			ovf_out_q <= ovf_q;
		end
	end

	assign value       = value_q;
	assign stop_offset = offset_q;
	assign overflowed  = ovf_out_q;

endmodule

// ===== hw/rtl/string_to_unsigned_parser.sv =====
// Top level of the streaming string-to-unsigned parser.
// Instantiates stu_ctrl and stu_datapath; depends on stu_pkg.
//
// Usage:
// The input channel (in_valid, in_ready, char_code) carries one character
// per word. A zero character ends the string and yields exactly one result
// word on the output channel (out_valid, out_ready, value, stop_offset,
// overflowed); all other characters yield nothing.
// The radix register is written through cfg_wr_en/cfg_wr_data; the user must write it only while the
// parser is idle, which the block itself does not enforce; 0 selects base detection from the prefix.
// Throughput is one character per cycle while no result waits with out_ready low; the digit step is a
// combinational 64 x 6 bit multiply-accumulate with its overflow check.
// The result appears on the output in the cycle after the terminator is taken.
// The result sits in an output register; while it waits with out_ready low,
// in_ready is low and every character stalls, not only the next terminator.
// Reset clears the scan state, the radix register (to 0) and out_valid.
// Position counting saturates at MAX_LEN.

module string_to_unsigned_parser
	import stu_pkg::*;
#(
	parameter int MAX_LEN = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [RADIX_W-1:0]  cfg_wr_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CHAR_W-1:0]   char_code,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [VALUE_W-1:0]  value,
	output logic [OFFSET_W-1:0] stop_offset,
	output logic                overflowed
);

	dp_cmd_t    cmd;
	dp_status_t status;

	stu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	stu_datapath #(
		.MAX_LEN (MAX_LEN)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.char_code   (char_code),
		.cmd         (cmd),
		.status      (status),
		.value       (value),
		.stop_offset (stop_offset),
		.overflowed  (overflowed)
	);

	// The input only stalls behind a result that is still waiting.
	a_stall_only_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled without a pending result");

	// A taken terminator always produces a result word.
	a_term_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && char_code == CH_NUL) |=> out_valid)
		else $error("terminator accepted but no result");

	// A new result only follows a taken terminator.
	a_result_from_term: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && char_code == CH_NUL))
		else $error("result appeared without a terminator");

	// An overflowed result carries the all-ones value.
	a_ovf_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflowed) |-> (value == '1))
		else $error("overflow flagged with a value other than all ones");

endmodule

// ===== tb/sv/string_to_unsigned_parser_checker.sv =====
// Checker for the string-to-unsigned parser: follows the radix register and
// every accepted character word, predicts each result word and compares it.
// Depends on stu_pkg for widths, character codes, bases and scan phases.
`timescale 1ns / 100ps

module string_to_unsigned_parser_checker
	import stu_pkg::*;
#(
	parameter int MAX_LEN = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [RADIX_W-1:0]  cfg_wr_data,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [CHAR_W-1:0]   char_code,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [VALUE_W-1:0]  value,
	input  logic [OFFSET_W-1:0] stop_offset,
	input  logic                overflowed,
	output int                  mismatch_count,
	output int                  outstanding
);

	localparam int unsigned NO_DIGIT = 255;
	localparam int WIDE_W = VALUE_W + RADIX_W + 1;

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [OFFSET_W-1:0] offset;
		logic                ovf;
	} parse_result_t;

	parse_result_t parse_results_q[$];

	logic [RADIX_W-1:0] radix_copy;
	phase_t             scan_phase;
	logic [VALUE_W-1:0] acc;
	logic               neg;
	logic [RADIX_W-1:0] base;
	int unsigned        pos;
	int unsigned        stop_pos;
	logic               ovf;

	function automatic int unsigned digit_of(logic [CHAR_W-1:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) return 32'(c - CH_ZERO);
		if (c >= CH_UA && c <= CH_UZ) return 32'(c - CH_UA) + 10;
		if (c >= CH_LA && c <= CH_LZ) return 32'(c - CH_LA) + 10;
		return NO_DIGIT;
	endfunction

	function automatic int unsigned bump(int unsigned p, int unsigned n);
		return (p + n > MAX_LEN) ? MAX_LEN : p + n;
	endfunction

	task automatic clear_scan();
		scan_phase = PH_WS;
		acc        = '0;
		neg        = 1'b0;
		base       = '0;
		pos        = 0;
		stop_pos   = 0;
		ovf        = 1'b0;
	endtask

	task automatic take_digit(logic [CHAR_W-1:0] c);
		int unsigned d;
		logic [WIDE_W-1:0] wide;
		d = digit_of(c);
		if (base == 0 || d >= 32'(base)) begin
			stop_pos   = pos;
			scan_phase = PH_STOPPED;
		end else begin
			wide = WIDE_W'(acc) * WIDE_W'(base) + WIDE_W'(d);
			if (wide[WIDE_W-1:VALUE_W] != 0) begin
				stop_pos   = pos;
				ovf        = 1'b1;
				scan_phase = PH_STOPPED;
			end else begin
				acc = wide[VALUE_W-1:0];
				pos = bump(pos, 1);
			end
		end
	endtask

	// First character after whitespace and sign: the base is latched here.
	task automatic take_first(logic [CHAR_W-1:0] c);
		base = radix_copy;
		if (c == CH_ZERO && (base == 0 || base == BASE_HEX)) begin
			scan_phase = PH_ZERO;
		end else begin
			scan_phase = PH_DIGITS;
			if (base == 0) begin
				base = BASE_DEC;
				take_digit(c);
			end else if (base == BASE_OCT && c == CH_ZERO) begin
				pos = bump(pos, 1);
			end else begin
				take_digit(c);
			end
		end
	endtask

	task automatic scan_char(logic [CHAR_W-1:0] c);
		case (scan_phase)
			PH_WS: begin
				if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
					pos = bump(pos, 1);
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					neg        = (c == CH_MINUS);
					pos        = bump(pos, 1);
					scan_phase = PH_SIGNED;
				end else begin
					take_first(c);
				end
			end
			PH_SIGNED: take_first(c);
			PH_ZERO: begin
				scan_phase = PH_DIGITS;
				if (c == CH_LX || c == CH_UX) begin
					base = BASE_HEX;
					pos  = bump(pos, 2);
				end else begin
					if (base == 0)
						base = BASE_OCT;
					pos = bump(pos, 1);
					take_digit(c);
				end
			end
			PH_DIGITS: take_digit(c);
			default: ;
		endcase
	endtask

	task automatic finish_string();
		parse_result_t r;
		int unsigned endpos;
		if (scan_phase == PH_STOPPED)
			endpos = stop_pos;
		else if (scan_phase == PH_ZERO)
			endpos = bump(pos, 1);
		else
			endpos = pos;
		r.value = acc;
		r.ovf   = 1'b0;
		if (scan_phase == PH_STOPPED && ovf) begin
			r.value = '1;
			r.ovf   = 1'b1;
		end else if (endpos == 0) begin
			r.value = '0;
		end else if (neg) begin
			// Magnitudes above the signed maximum collapse to zero, except 2^63.
			if (acc[VALUE_W-1])
				r.value = (acc == {1'b1, {(VALUE_W-1){1'b0}}}) ? acc : '0;
			else
				r.value = -acc;
		end
		r.offset = endpos[OFFSET_W-1:0];
		parse_results_q.push_back(r);
		clear_scan();
	endtask

	task automatic check_result();
		parse_result_t want;
		if (parse_results_q.size() == 0) begin
			mismatch_count++;
			$display("%0t: result word with no string pending: value %h offset %0d overflowed %b",
				$time, value, stop_offset, overflowed);
		end else begin
			want = parse_results_q.pop_front();
			if (value !== want.value) begin
				mismatch_count++;
				$display("%0t: value mismatch, expected %h, actual %h", $time, want.value, value);
			end
			if (stop_offset !== want.offset) begin
				mismatch_count++;
				$display("%0t: stop_offset mismatch, expected %0d, actual %0d",
					$time, want.offset, stop_offset);
			end
			if (overflowed !== want.ovf) begin
				mismatch_count++;
				$display("%0t: overflowed mismatch, expected %b, actual %b",
					$time, want.ovf, overflowed);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_copy = '0;
			clear_scan();
			parse_results_q.delete();
			mismatch_count = 0;
			outstanding    = 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			// A character word sees the radix from before a write on the same edge.
			if (in_valid && in_ready) begin
				if (char_code == CH_NUL)
					finish_string();
				else
					scan_char(char_code);
			end
			if (cfg_wr_en)
				radix_copy = cfg_wr_data;
			outstanding = parse_results_q.size();
		end
	end

endmodule

// ===== tb/sv/string_to_unsigned_parser_tb.sv =====
// Top of the string-to-unsigned parser testbench: clock, reset, character
// stimulus, result back-pressure and the verdict. Depends on stu_pkg, the
// block string_to_unsigned_parser and string_to_unsigned_parser_checker.
`timescale 1ns / 100ps

module string_to_unsigned_parser_tb;
	import stu_pkg::*;

	localparam int MAX_LEN = 4096;
	localparam int SETTLE_CYCLES = 3;
	localparam int PHASE_CHARS = 120;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [RADIX_W-1:0]  cfg_wr_data;
	logic                in_valid;
	logic                in_ready;
	logic [CHAR_W-1:0]   char_code;
	logic                out_valid;
	logic                out_ready;
	logic [VALUE_W-1:0]  value;
	logic [OFFSET_W-1:0] stop_offset;
	logic                overflowed;

	int          mismatch_count;
	int          outstanding;
	int unsigned idle_pct;
	int unsigned chars_sent;

	string_to_unsigned_parser #(.MAX_LEN(MAX_LEN)) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_code   (char_code),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value       (value),
		.stop_offset (stop_offset),
		.overflowed  (overflowed)
	);

	string_to_unsigned_parser_checker #(.MAX_LEN(MAX_LEN)) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.char_code      (char_code),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.value          (value),
		.stop_offset    (stop_offset),
		.overflowed     (overflowed),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("** string_to_unsigned_parser: FAILED **");
		$finish;
	end

	// Result side: random stall bursts, controlled by the same idle setting.
	initial begin : result_sink
		int unsigned n;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) < idle_pct) begin
				n = $urandom_range(1, 10);
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Called right after a rising edge; returns at the edge that takes the word.
	// in_ready only changes at rising edges, so it is sampled on the falling edge.
	task automatic send_char(logic [CHAR_W-1:0] c);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic send_string(string s);
		send_text(s);
		send_char(CH_NUL);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_radix(logic [RADIX_W-1:0] r);
		settle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= r;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [CHAR_W-1:0] digit_char(int unsigned v);
		if (v < 10)
			return CHAR_W'(CH_ZERO + v);
		return CHAR_W'(($urandom_range(0, 1) ? CH_LA : CH_UA) + v - 10);
	endfunction

	function automatic logic [CHAR_W-1:0] blank_char();
		int unsigned x;
		x = $urandom_range(0, 5);
		return (x == 5) ? CH_SPACE : CHAR_W'(CH_TAB + x);
	endfunction

	// Mostly well-formed numbers with random content, some plain noise.
	task automatic send_random_string(logic [RADIX_W-1:0] rad);
		logic [CHAR_W-1:0] text[$];
		int unsigned n;
		int unsigned eff;
		logic        top_digits;
		if ($urandom_range(0, 9) == 0) begin
			n = $urandom_range(0, 12);
			repeat (n) text.push_back(CHAR_W'($urandom_range(1, 255)));
		end else begin
			repeat ($urandom_range(0, 3)) text.push_back(blank_char());
			case ($urandom_range(0, 3))
				0: text.push_back(CH_PLUS);
				1: text.push_back(CH_MINUS);
				default: ;
			endcase
			eff = 32'(rad);
			if (rad == 0) begin
				case ($urandom_range(0, 2))
					0: begin
						text.push_back(CH_ZERO);
						text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
						eff = 32'(BASE_HEX);
					end
					1: begin
						text.push_back(CH_ZERO);
						eff = 32'(BASE_OCT);
					end
					default: begin
						text.push_back(CHAR_W'(CH_ZERO + $urandom_range(1, 9)));
						eff = 32'(BASE_DEC);
					end
				endcase
			end else if (rad == BASE_HEX && $urandom_range(0, 1)) begin
				text.push_back(CH_ZERO);
				text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
			end else if (rad == BASE_OCT && $urandom_range(0, 1)) begin
				text.push_back(CH_ZERO);
			end
			if (eff > 36)
				eff = 36;
			// Long runs reach the overflow boundary; top digits get there fastest.
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 70) : $urandom_range(0, 12);
			top_digits = ($urandom_range(0, 3) == 0);
			repeat (n) text.push_back(digit_char(top_digits ? eff - 1 : $urandom_range(0, eff - 1)));
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 4)) text.push_back(CHAR_W'($urandom_range(1, 255)));
		end
		foreach (text[i])
			send_char(text[i]);
		send_char(CH_NUL);
	endtask

	initial begin
		logic [RADIX_W-1:0] radix_plan[11];
		int unsigned start;
		radix_plan = '{6'd0, 6'd10, 6'd16, 6'd8, 6'd36, 6'd2, 6'd1, 6'd63, 6'd37, 6'd0, 6'd0};
		radix_plan[9] = RADIX_W'($urandom_range(0, 63));
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		char_code   = CH_NUL;
		idle_pct    = 20;
		chars_sent  = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Base detection from the prefix.
		set_radix(6'd0);
		send_string("");
		send_text(" \t\n");
		send_char(8'h0B);
		send_char(8'h0C);
		send_char(CH_CR);
		send_string("123");
		send_string("+42");
		send_string("-42");
		send_string("-");
		send_string("0x1F");
		send_string("0X");
		send_string("0xg");
		send_string("0");
		send_string("017");
		send_string("089");
		send_string("abc");
		send_string("18446744073709551615");
		send_string("18446744073709551616");
		send_string("-9223372036854775808");
		send_string("-9223372036854775809");
		send_string("-0x8000000000000000");
		send_text("12");
		send_char(8'hFF);
		send_char(8'h80);
		send_string(" junk");

		set_radix(BASE_HEX);
		send_string("  -0xFFFFFFFFFFFFFFFF");
		send_string("ffffffffffffffff1");
		set_radix(BASE_OCT);
		send_string("0777");
		send_string("-01");
		set_radix(6'd36);
		send_string("zZ9");
		set_radix(6'd1);
		send_string("01");
		set_radix(6'd63);
		send_string("zz");
		set_radix(6'd2);
		send_string("1010");

		foreach (radix_plan[k]) begin
			set_radix(radix_plan[k]);
			idle_pct = (k % 4 == 3 || k == $size(radix_plan) - 1) ? 0 : $urandom_range(10, 50);
			start = chars_sent;
			while (chars_sent - start < PHASE_CHARS)
				send_random_string(radix_plan[k]);
		end

		settle();
		if (mismatch_count == 0 && outstanding == 0)
			$display("** string_to_unsigned_parser: PASSED **");
		else
			$display("** string_to_unsigned_parser: FAILED **");
		$finish;
	end

endmodule
